// ===== design/fast_float_square_root_defines.svh =====
// Assertion macros for the checker file of the square root block.
`ifndef FAST_FLOAT_SQUARE_ROOT_DEFINES_SVH
`define FAST_FLOAT_SQUARE_ROOT_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define FSR_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define FSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication that is also checked around reset.
`define FSR_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/fsr_pkg.sv =====
// Types, constants and per-stage float functions of the square root pipeline.
package fsr_pkg;

    // Stage counts of the arithmetic units
    localparam int DIV_LAT = 29;
    localparam int ADD_LAT = 6;
    localparam int MUL_LAT = 3;
    localparam int QUO_BITS = 26;

    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC00000;
    localparam logic [31:0] QUIET_BIT    = 32'h00400000;
    localparam logic [30:0] INF_MAG      = 31'h7F800000;
    // 2^29 - 2^22, added to the halved operand for the first guess
    localparam logic [31:0] GUESS_BIAS   = 32'h1FC00000;

    // Unrounded number: value = sig / 2^26 * 2^(exp - 127), plus sticky
    typedef struct packed {
        logic               spec;
        logic [31:0]        spec_bits;
        logic               sign;
        logic signed [10:0] exp;
        logic [26:0]        sig;
        logic               sticky;
    } fsr_num_t;

    typedef struct packed {
        logic [23:0]        sig;
        logic signed [10:0] exp;
    } fsr_unp_t;

    // One stage of the restoring divider
    typedef struct packed {
        logic               spec;
        logic [31:0]        spec_bits;
        logic               sign;
        logic signed [10:0] exp;
        logic [24:0]        rem;
        logic [23:0]        dsor;
        logic [25:0]        quo;
    } fsr_div_st_t;

    // Adder after unpack and align
    typedef struct packed {
        logic               spec;
        logic [31:0]        spec_bits;
        logic               sign;
        logic               sub;
        logic               zsign;
        logic signed [10:0] exp;
        logic [26:0]        big;
        logic [26:0]        small_sig;
        logic [7:0]         diff;
    } fsr_add_t;

    // Adder after the add or subtract
    typedef struct packed {
        logic               spec;
        logic [31:0]        spec_bits;
        logic               sign;
        logic               zsign;
        logic signed [10:0] exp;
        logic [27:0]        sum;
    } fsr_sum_t;

    function automatic logic fsr_is_nan(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    function automatic logic fsr_is_inf(input logic [31:0] b);
        return b[30:0] == INF_MAG;
    endfunction

    function automatic logic fsr_is_zero(input logic [31:0] b);
        return b[30:0] == 31'd0;
    endfunction

    // Leading zero count, 27 for an all-zero word
    function automatic logic [4:0] fsr_clz27(input logic [26:0] v);
        logic [4:0] lz;
        lz = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (v[i]) begin
                lz = 5'(26 - i);
            end
        end
        return lz;
    endfunction

    // Normalized 24-bit significand and exponent of a finite nonzero pattern
    function automatic fsr_unp_t fsr_unpack(input logic [31:0] b);
        fsr_unp_t   r;
        logic [4:0] lz;
        lz = fsr_clz27({1'b0, b[22:0], 3'b000});
        if (b[30:23] == 8'd0) begin
            r.sig = 24'({1'b0, b[22:0]} << lz);
            r.exp = 11'sd1 - $signed({6'd0, lz});
        end else begin
            r.sig = {1'b1, b[22:0]};
            r.exp = $signed({3'd0, b[30:23]});
        end
        return r;
    endfunction

    // Shift a tiny value right into the subnormal range
    function automatic fsr_num_t fsr_denorm(input fsr_num_t n);
        fsr_num_t    r;
        logic [10:0] sh_full;
        logic [4:0]  sh;
        logic [58:0] wide;
        r       = n;
        sh_full = 11'(11'sd1 - n.exp);
        sh      = (sh_full > 11'd31) ? 5'd31 : sh_full[4:0];
        wide    = {n.sig, 32'd0} >> sh;
        if (!n.spec && (n.exp < 11'sd1)) begin
            r.sig    = wide[58:32];
            r.sticky = n.sticky | (|wide[31:0]);
            r.exp    = 11'sd1;
        end
        return r;
    endfunction

    // Round to nearest even and pack; a carry out of the mantissa bumps the exponent
    function automatic logic [31:0] fsr_round(input fsr_num_t n);
        logic [23:0]        mant;
        logic               up;
        logic [24:0]        mr;
        logic signed [33:0] pk;
        logic [31:0]        r;
        mant = n.sig[26:3];
        up   = n.sig[2] & (n.sticky | (|n.sig[1:0]) | mant[0]);
        mr   = {1'b0, mant} + 25'(up);
        pk   = ((34'(n.exp) - 34'sd1) <<< 23) + $signed({9'd0, mr});
        if (n.spec) begin
            r = n.spec_bits;
        end else if (n.sig == 27'd0) begin
            r = {n.sign, 31'd0};
        end else if (pk >= $signed({3'd0, INF_MAG})) begin
            r = {n.sign, INF_MAG};
        end else begin
            r = {n.sign, pk[30:0]};
        end
        return r;
    endfunction

    // Divider entry: special operands and the first remainder
    function automatic fsr_div_st_t fsr_div_start(input logic [31:0] n, input logic [31:0] d);
        fsr_div_st_t s;
        fsr_unp_t    un;
        fsr_unp_t    ud;
        logic        sg;
        un = fsr_unpack(n);
        ud = fsr_unpack(d);
        sg = n[31] ^ d[31];
        s  = '0;
        s.sign = sg;
        s.dsor = ud.sig;
        s.exp  = un.exp - ud.exp + 11'sd127;
        if (un.sig >= ud.sig) begin
            s.rem = {1'b0, un.sig};
        end else begin
            s.rem = {un.sig, 1'b0};
            s.exp = un.exp - ud.exp + 11'sd126;
        end
        s.spec = 1'b1;
        if (fsr_is_nan(n)) begin
            s.spec_bits = n | QUIET_BIT;
        end else if (fsr_is_nan(d)) begin
            s.spec_bits = d | QUIET_BIT;
        end else if ((fsr_is_inf(n) && fsr_is_inf(d)) || (fsr_is_zero(n) && fsr_is_zero(d)))
        begin
            s.spec_bits = QNAN_DEFAULT;
        end else if (fsr_is_inf(n) || fsr_is_zero(d)) begin
            s.spec_bits = {sg, INF_MAG};
        end else if (fsr_is_inf(d) || fsr_is_zero(n)) begin
            s.spec_bits = {sg, 31'd0};
        end else begin
            s.spec = 1'b0;
        end
        return s;
    endfunction

    // One quotient bit: compare, subtract, shift
    function automatic fsr_div_st_t fsr_div_step(input fsr_div_st_t s);
        fsr_div_st_t r;
        logic [24:0] diff;
        r    = s;
        diff = s.rem - {1'b0, s.dsor};
        if (s.rem >= {1'b0, s.dsor}) begin
            r.quo = {s.quo[24:0], 1'b1};
            r.rem = {diff[23:0], 1'b0};
        end else begin
            r.quo = {s.quo[24:0], 1'b0};
            r.rem = {s.rem[23:0], 1'b0};
        end
        return r;
    endfunction

    function automatic fsr_num_t fsr_div_finish(input fsr_div_st_t s);
        fsr_num_t r;
        r.spec      = s.spec;
        r.spec_bits = s.spec_bits;
        r.sign      = s.sign;
        r.exp       = s.exp;
        r.sig       = {s.quo, 1'b0};
        r.sticky    = |s.rem;
        return r;
    endfunction

    // Adder entry: specials, order by magnitude
    function automatic fsr_add_t fsr_add_unpack(input logic [31:0] a, input logic [31:0] b);
        fsr_add_t    t;
        logic [31:0] bg;
        logic [31:0] sm;
        logic [7:0]  eb;
        logic [7:0]  es;
        bg = (b[30:0] > a[30:0]) ? b : a;
        sm = (b[30:0] > a[30:0]) ? a : b;
        eb = (bg[30:23] == 8'd0) ? 8'd1 : bg[30:23];
        es = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
        t  = '0;
        t.sign      = bg[31];
        t.sub       = a[31] ^ b[31];
        t.zsign     = a[31] & b[31];
        t.exp       = $signed({3'd0, eb});
        t.big       = {bg[30:23] != 8'd0, bg[22:0], 3'b000};
        t.small_sig = {sm[30:23] != 8'd0, sm[22:0], 3'b000};
        t.diff      = eb - es;
        t.spec      = 1'b1;
        if (fsr_is_nan(a)) begin
            t.spec_bits = a | QUIET_BIT;
        end else if (fsr_is_nan(b)) begin
            t.spec_bits = b | QUIET_BIT;
        end else if (fsr_is_inf(a) && fsr_is_inf(b) && (a[31] != b[31])) begin
            t.spec_bits = QNAN_DEFAULT;
        end else if (fsr_is_inf(a)) begin
            t.spec_bits = a;
        end else if (fsr_is_inf(b)) begin
            t.spec_bits = b;
        end else begin
            t.spec = 1'b0;
        end
        return t;
    endfunction

    // Align the smaller operand, jamming lost bits into its lowest bit
    function automatic fsr_add_t fsr_add_align(input fsr_add_t t);
        fsr_add_t    r;
        logic [4:0]  sh;
        logic [58:0] wide;
        r    = t;
        sh   = (t.diff > 8'd31) ? 5'd31 : t.diff[4:0];
        wide = {t.small_sig, 32'd0} >> sh;
        r.small_sig = wide[58:32] | {26'd0, |wide[31:0]};
        return r;
    endfunction

    function automatic fsr_sum_t fsr_add_sum(input fsr_add_t t);
        fsr_sum_t r;
        r.spec      = t.spec;
        r.spec_bits = t.spec_bits;
        r.sign      = t.sign;
        r.zsign     = t.zsign;
        r.exp       = t.exp;
        r.sum       = t.sub ? ({1'b0, t.big} - {1'b0, t.small_sig})
                            : ({1'b0, t.big} + {1'b0, t.small_sig});
        return r;
    endfunction

    // Bring the leading one to bit 26
    function automatic fsr_num_t fsr_add_norm(input fsr_sum_t s);
        fsr_num_t   r;
        logic [4:0] lz;
        lz = fsr_clz27(s.sum[26:0]);
        r.spec      = s.spec;
        r.spec_bits = s.spec_bits;
        r.sign      = s.sign;
        r.sticky    = 1'b0;
        if (s.sum[27]) begin
            r.sig    = s.sum[27:1];
            r.sticky = s.sum[0];
            r.exp    = s.exp + 11'sd1;
        end else if (s.sum == 28'd0) begin
            r.sign = s.zsign;
            r.sig  = 27'd0;
            r.exp  = 11'sd1;
        end else begin
            r.sig = s.sum[26:0] << lz;
            r.exp = s.exp - $signed({6'd0, lz});
        end
        return r;
    endfunction

    // Entry of the multiply by one quarter
    function automatic fsr_num_t fsr_quarter(input logic [31:0] y);
        fsr_num_t r;
        r = '0;
        r.sign = y[31];
        r.sig  = {y[30:23] != 8'd0, y[22:0], 3'b000};
        r.exp  = ((y[30:23] == 8'd0) ? 11'sd1 : $signed({3'd0, y[30:23]})) - 11'sd2;
        r.spec = 1'b1;
        if (fsr_is_nan(y)) begin
            r.spec_bits = y | QUIET_BIT;
        end else if (fsr_is_inf(y) || fsr_is_zero(y)) begin
            r.spec_bits = y;
        end else begin
            r.spec = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== design/fast_float_square_root.sv =====
// Approximate binary32 square root: bit-level guess and two Babylonian steps.
//
// Input channel s_valid/s_ready/s_operand_bits takes one binary32 pattern per
// request; output channel m_valid/m_ready/m_root_bits returns one result for
// each request, in order. Results keep no state between requests.
// Throughput is one request per cycle while s_ready is high. The input
// register loads at the accepting edge; then follow a 29-stage divider
// (one quotient bit per bit stage), a 6-stage adder, a second divider
// and adder, and the output register. The multiply by one quarter runs
// beside the second divider.
// The whole pipeline advances on one enable; s_ready drops only once a second
// result waits in the skid register behind a held output, and rises again
// after the edge at which the receiver takes the held result.
// Reset (aresetn low, synchronous) clears every valid bit and the skid valid
// bit; data registers are not reset. The receiver may stall for any
// time: nothing is lost or repeated.
module fast_float_square_root
    import fsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_operand_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_root_bits
);

    localparam int PIPE_DEPTH = 1 + 2 * (DIV_LAT + ADD_LAT);
    localparam int X_DLY      = DIV_LAT + ADD_LAT;
    localparam int Q_DLY      = DIV_LAT - MUL_LAT;

    logic        en;
    logic        v_reg [0:PIPE_DEPTH-1];
    logic [31:0] x0_reg;
    logic [31:0] g0_reg;
    logic [31:0] xd_reg [0:X_DLY-1];
    logic [31:0] gd_reg [0:DIV_LAT-1];
    logic [31:0] qd_reg [0:Q_DLY-1];
    fsr_num_t    qm0_reg;
    fsr_num_t    qm1_reg;
    logic [31:0] qm2_reg;
    logic [31:0] q1_bits;
    logic [31:0] q2_bits;
    logic [31:0] add_a [0:1];
    logic [31:0] add_b [0:1];
    logic [31:0] add_o [0:1];
    logic [31:0] y_bits;
    logic        m_valid_reg;
    logic [31:0] m_root_reg;
    logic        skid_valid_reg;
    logic [31:0] skid_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= s_valid;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // Input register and initial guess
    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg <= s_operand_bits;
            g0_reg <= {s_operand_bits[31], s_operand_bits[31:1]} + GUESS_BIAS;
        end
    end

    // Operand delay lines
    always_ff @(posedge aclk) begin
        if (en) begin
            xd_reg[0] <= x0_reg;
            for (int i = 1; i < X_DLY; i++) begin
                xd_reg[i] <= xd_reg[i-1];
            end
            gd_reg[0] <= g0_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                gd_reg[i] <= gd_reg[i-1];
            end
        end
    end

    // x / g
    fsr_div u_div1 (
        .aclk     (aclk),
        .en       (en),
        .num_bits (x0_reg),
        .den_bits (g0_reg),
        .quo_bits (q1_bits)
    );

    // y = g + x/g, then r = y/4 + x/y
    assign add_a[0] = gd_reg[DIV_LAT-1];
    assign add_b[0] = q1_bits;
    assign y_bits   = add_o[0];
    assign add_a[1] = qd_reg[Q_DLY-1];
    assign add_b[1] = q2_bits;

    // Two six-stage adders
    for (genvar u = 0; u < 2; u++) begin : g_add
        fsr_add_t    a0_reg;
        fsr_add_t    a1_reg;
        fsr_sum_t    a2_reg;
        fsr_num_t    a3_reg;
        fsr_num_t    a4_reg;
        logic [31:0] a5_reg;

        always_ff @(posedge aclk) begin
            if (en) begin
                a0_reg <= fsr_add_unpack(add_a[u], add_b[u]);
                a1_reg <= fsr_add_align(a0_reg);
                a2_reg <= fsr_add_sum(a1_reg);
                a3_reg <= fsr_add_norm(a2_reg);
                a4_reg <= fsr_denorm(a3_reg);
                a5_reg <= fsr_round(a4_reg);
            end
        end

        assign add_o[u] = a5_reg;
    end

    // x / y
    fsr_div u_div2 (
        .aclk     (aclk),
        .en       (en),
        .num_bits (xd_reg[X_DLY-1]),
        .den_bits (y_bits),
        .quo_bits (q2_bits)
    );

    // 0.25 * y, delayed to meet x/y
    always_ff @(posedge aclk) begin
        if (en) begin
            qm0_reg   <= fsr_quarter(y_bits);
            qm1_reg   <= fsr_denorm(qm0_reg);
            qm2_reg   <= fsr_round(qm1_reg);
            qd_reg[0] <= qm2_reg;
            for (int i = 1; i < Q_DLY; i++) begin
                qd_reg[i] <= qd_reg[i-1];
            end
        end
    end

    // Output register with one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= v_reg[PIPE_DEPTH-1];
            end
        end else if (v_reg[PIPE_DEPTH-1] && en) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_root_reg <= skid_valid_reg ? skid_reg : add_o[1];
        end else if (en) begin
            skid_reg <= add_o[1];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_root_bits = m_root_reg;

endmodule

// ===== design/fsr_div.sv =====
// Pipelined binary32 divider: one quotient bit per step stage, round to nearest even.
module fsr_div
    import fsr_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] num_bits,
    input  logic [31:0] den_bits,
    output logic [31:0] quo_bits
);

    fsr_div_st_t st_reg [0:QUO_BITS];
    fsr_num_t    dn_reg;
    logic [31:0] quo_reg;

    // Entry: specials, normalization, first remainder
    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= fsr_div_start(num_bits, den_bits);
        end
    end

    // Quotient bit stages
    for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k+1] <= fsr_div_step(st_reg[k]);
            end
        end
    end

    // Subnormal shift, then rounding
    always_ff @(posedge aclk) begin
        if (en) begin
            dn_reg  <= fsr_denorm(fsr_div_finish(st_reg[QUO_BITS]));
            quo_reg <= fsr_round(dn_reg);
        end
    end

    assign quo_bits = quo_reg;

endmodule

// ===== design/fsr_checker.sv =====
// Port-level checks of the square root block, bound to its top level.
`include "fast_float_square_root_defines.svh"

module fsr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_root_bits
);

    // A held result stays put
    `FSR_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_root_bits), "result changed while stalled")

    // Input backpressure only while a result is waiting
    `FSR_ASSERT(a_stall_has_result, !s_ready, m_valid, "s_ready low with no result waiting")

    // Ready drops only after a refused result
    `FSR_ASSERT(a_ready_fall, $fell(s_ready), $past(m_valid && !m_ready), "s_ready fell without a receiver stall")

    // Reset empties the block
    `FSR_ASSERT_ALWAYS(a_reset_empty, $past(!aresetn), !m_valid && s_ready, "block not empty after reset")

endmodule

bind fast_float_square_root fsr_checker u_fsr_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_root_bits (m_root_bits)
);
